FILE: rtl/oqkr_pkg.sv
// ----------------------------------------------------------------------------
// Ordered queue with keyed removal: shared types and codes
// Holds the transaction payload types and the operation and status codes.
// ----------------------------------------------------------------------------
package oqkr_pkg;

	localparam int KEY_W = 32;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [1:0]       kind_t;
	typedef logic [1:0]       status_t;
	typedef logic [4:0]       entry_count_t;

	localparam kind_t KIND_PUSH  = 2'd0;
	localparam kind_t KIND_ERASE = 2'd1;
	localparam kind_t KIND_PEEK  = 2'd2;

	localparam status_t STATUS_DONE      = 2'd0;
	localparam status_t STATUS_NOT_FOUND = 2'd1;
	localparam status_t STATUS_EMPTY     = 2'd2;
	localparam status_t STATUS_FULL      = 2'd3;

	typedef struct packed {
		kind_t kind;
		key_t  key;
	} req_t;

	typedef struct packed {
		status_t      status;
		logic         head_valid;
		key_t         head_key;
		entry_count_t entry_count;
	} rsp_t;

endpackage

FILE: rtl/oqkr_stream_if.sv
// ----------------------------------------------------------------------------
// Ordered queue with keyed removal: valid/ready channel
// One transaction moves when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface oqkr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ordered_queue_with_keyed_removal_top.sv
// ----------------------------------------------------------------------------
// Ordered queue with keyed removal
// Queue of 32-bit keys in arrival order with push, erase by key and peek.
// ----------------------------------------------------------------------------
// The req channel carries one operation per transaction: push a key at the
// tail, erase the first entry equal to the key, or peek. The rsp channel
// returns exactly one transaction per operation with the status, the head key
// and the entry count as they stand after the operation.
// The block takes one operation at a time and is not ready until the result
// has been taken. Push and peek offer it in the cycle after acceptance.
// An erase walks the key memory from the head with a single equality compare,
// one entry per cycle, then closes the gap with one read and one write per
// cycle.
// The memory has one read and one write port with registered read data, and
// that port pair sets the rate.
// Reset empties the queue at once; the key memory itself is not cleared.
// When the receiver stalls, the result is held and no new operation is taken.
module ordered_queue_with_keyed_removal_top #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	oqkr_stream_if.sink   req,
	oqkr_stream_if.source rsp
);

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W = IDX_W + 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_RESP
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     ptr_q;
	oqkr_pkg::key_t       key_q;
	oqkr_pkg::key_t       head_q;
	oqkr_pkg::status_t    status_q;

	oqkr_pkg::key_t       entry_keys_q [QUEUE_DEPTH];
	oqkr_pkg::key_t       rdata_q;

	logic [CMP_W-1:0]     ptr_p1;
	logic [CMP_W-1:0]     ptr_p2;
	logic [CMP_W-1:0]     count_ext;
	logic [IDX_W-1:0]     rd_addr;
	logic                 mem_we;
	logic [IDX_W-1:0]     wr_addr;
	oqkr_pkg::key_t       wr_data;
	logic                 full;
	logic                 key_match;
	logic                 req_fire;

	assign ptr_p1    = CMP_W'(ptr_q) + CMP_W'(1);
	assign ptr_p2    = CMP_W'(ptr_q) + CMP_W'(2);
	assign count_ext = CMP_W'(count_q);
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign key_match = (rdata_q == key_q);
	assign req_fire  = req.valid && req.ready;

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = (state_q == ST_RESP);

	assign rsp.data.status      = status_q;
	assign rsp.data.head_valid  = (count_q != '0);
	assign rsp.data.head_key    = (count_q != '0) ? head_q : '0;
	assign rsp.data.entry_count = oqkr_pkg::entry_count_t'(count_q);

	always_comb begin
		unique case (state_q)
			ST_SCAN:  rd_addr = ptr_p1[IDX_W-1:0];
			ST_SHIFT: rd_addr = ptr_p2[IDX_W-1:0];
			default:  rd_addr = '0;
		endcase
	end

	always_comb begin
		mem_we  = 1'b0;
		wr_addr = ptr_q;
		wr_data = rdata_q;
		if (state_q == ST_SHIFT) begin
			mem_we = 1'b1;
		end else if (req_fire && (req.data.kind == oqkr_pkg::KIND_PUSH) && !full) begin
			mem_we  = 1'b1;
			wr_addr = count_q[IDX_W-1:0];
			wr_data = req.data.key;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_keys_q[wr_addr] <= wr_data;
		end
		rdata_q <= entry_keys_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			ptr_q    <= '0;
			status_q <= oqkr_pkg::STATUS_DONE;
			key_q    <= '0;
			head_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						key_q    <= req.data.key;
						status_q <= oqkr_pkg::STATUS_DONE;
						ptr_q    <= '0;
						state_q  <= ST_RESP;
						unique case (req.data.kind)
							oqkr_pkg::KIND_PUSH: begin
								if (full) begin
									status_q <= oqkr_pkg::STATUS_FULL;
								end else begin
									count_q <= count_q + CNT_W'(1);
									if (count_q == '0) begin
										head_q <= req.data.key;
									end
								end
							end
							oqkr_pkg::KIND_ERASE: begin
								if (count_q == '0) begin
									status_q <= oqkr_pkg::STATUS_EMPTY;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (key_match) begin
						if (ptr_p1 < count_ext) begin
							state_q <= ST_SHIFT;
						end else begin
							count_q <= count_q - CNT_W'(1);
							state_q <= ST_RESP;
						end
					end else if (ptr_p1 < count_ext) begin
						ptr_q <= ptr_p1[IDX_W-1:0];
					end else begin
						status_q <= oqkr_pkg::STATUS_NOT_FOUND;
						state_q  <= ST_RESP;
					end
				end
				ST_SHIFT: begin
					if (ptr_q == '0) begin
						head_q <= rdata_q;
					end
					if (ptr_p2 < count_ext) begin
						ptr_q <= ptr_p1[IDX_W-1:0];
					end else begin
						count_q <= count_q - CNT_W'(1);
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
